[rtl/stl_pkg.sv]
// ----------------------------------------------------------------------------
// stl_pkg
// Shared types and constants of the slope threshold lick detector.
// ----------------------------------------------------------------------------
`default_nettype none

package stl_pkg;

    localparam int SAMPLE_BITS_DEF = 10;
    localparam int TIME_W          = 32;
    localparam int CFG_W           = 16;
    localparam int CFG_IDX_W       = 2;
    localparam int OUT_W           = 8;
    localparam int Q_SHIFT         = 8;
    localparam int PROD_W          = CFG_W + TIME_W;

    localparam logic [TIME_W-1:0] MIN_DT_MS = TIME_W'(5);

    localparam logic [CFG_W-1:0] SLOPE_THRESHOLD_RST = CFG_W'(397);
    localparam logic [CFG_W-1:0] LICK_HOLD_RST       = CFG_W'(50);
    localparam logic [CFG_W-1:0] MIN_GAP_RST         = CFG_W'(200);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLOPE_THRESHOLD = 2'd0,
        CFG_LICK_HOLD       = 2'd1,
        CFG_MIN_GAP         = 2'd2,
        CFG_REPORT_ENABLE   = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_START = 2'd1,
        EV_STOP  = 2'd2
    } t_event;

    typedef struct packed {
        logic [CFG_W-1:0] slope_threshold;
        logic [CFG_W-1:0] lick_hold_ms;
        logic [CFG_W-1:0] min_gap_ms;
        logic             report_enable;
    } t_cfg;

    typedef struct packed {
        logic        report_level;
        logic        lick_now;
        t_event      event_code;
    } t_result;

endpackage

`default_nettype wire

[rtl/stl_cfg_regs.sv]
// ----------------------------------------------------------------------------
// stl_cfg_regs
// Write-only configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module stl_cfg_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [stl_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  wire logic [stl_pkg::CFG_W-1:0]     i_cfg_wdata,
    output stl_pkg::t_cfg                      o_cfg
);

    stl_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slope_threshold <= stl_pkg::SLOPE_THRESHOLD_RST;
            r_cfg.lick_hold_ms    <= stl_pkg::LICK_HOLD_RST;
            r_cfg.min_gap_ms      <= stl_pkg::MIN_GAP_RST;
            r_cfg.report_enable   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                stl_pkg::CFG_SLOPE_THRESHOLD: r_cfg.slope_threshold <= i_cfg_wdata;
                stl_pkg::CFG_LICK_HOLD:       r_cfg.lick_hold_ms    <= i_cfg_wdata;
                stl_pkg::CFG_MIN_GAP:         r_cfg.min_gap_ms      <= i_cfg_wdata;
                stl_pkg::CFG_REPORT_ENABLE:   r_cfg.report_enable   <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

[rtl/stl_eval.sv]
// ----------------------------------------------------------------------------
// stl_eval
// Slope test, refractory timing and detector state, one sample per cycle while i_fire is high.
// ----------------------------------------------------------------------------
`default_nettype none

module stl_eval #(
    parameter int SAMPLE_BITS = stl_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_fire,
    input  wire logic [stl_pkg::TIME_W-1:0] i_now_ms,
    input  wire logic [SAMPLE_BITS-1:0]     i_sample,
    input  stl_pkg::t_cfg                   i_cfg,
    output stl_pkg::t_result                o_result
);

    logic [stl_pkg::TIME_W-1:0] r_last_eval_time;
    logic [SAMPLE_BITS-1:0]     r_last_sample;
    logic [stl_pkg::TIME_W-1:0] r_last_lick_time;
    logic                       r_lick_active;
    logic                       r_report_state;

    logic [stl_pkg::TIME_W-1:0] dt;
    logic [stl_pkg::TIME_W-1:0] gap;
    logic [SAMPLE_BITS:0]       diff;
    logic [stl_pkg::PROD_W-1:0] rhs;
    logic [stl_pkg::PROD_W-1:0] lhs;
    logic                       eval_ok;
    logic                       slope_ok;
    logic                       start;
    logic                       stop;
    logic                       n_report_state;

    always_comb begin
        dt       = i_now_ms - r_last_eval_time;
        gap      = i_now_ms - r_last_lick_time;
        diff     = {1'b0, i_sample} - {1'b0, r_last_sample};
        rhs      = stl_pkg::PROD_W'(i_cfg.slope_threshold) * stl_pkg::PROD_W'(dt);
        lhs      = stl_pkg::PROD_W'({diff[SAMPLE_BITS-1:0], {stl_pkg::Q_SHIFT{1'b0}}});
        eval_ok  = (dt > stl_pkg::MIN_DT_MS)
                && (gap > stl_pkg::TIME_W'(i_cfg.lick_hold_ms));
        // negative slope never passes
        slope_ok = !diff[SAMPLE_BITS] && (lhs > rhs);
        start    = eval_ok && slope_ok && (gap >= stl_pkg::TIME_W'(i_cfg.min_gap_ms));
        stop     = eval_ok && !start && r_lick_active;

        n_report_state = r_report_state;
        if (i_cfg.report_enable && start) begin
            n_report_state = 1'b1;
        end else if (i_cfg.report_enable && stop) begin
            n_report_state = 1'b0;
        end

        if (start) begin
            o_result.event_code = stl_pkg::EV_START;
        end else if (stop) begin
            o_result.event_code = stl_pkg::EV_STOP;
        end else begin
            o_result.event_code = stl_pkg::EV_NONE;
        end
        o_result.lick_now     = start;
        o_result.report_level = i_cfg.report_enable && n_report_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_eval_time <= '0;
            r_last_sample    <= '0;
            r_last_lick_time <= '0;
            r_lick_active    <= 1'b1;
            r_report_state   <= 1'b0;
        end else if (i_fire) begin
            if (eval_ok) begin
                r_last_eval_time <= i_now_ms;
                r_last_sample    <= i_sample;
            end
            if (start) begin
                r_last_lick_time <= i_now_ms;
                r_lick_active    <= 1'b1;
            end else if (stop) begin
                r_lick_active    <= 1'b0;
            end
            r_report_state <= n_report_state;
        end
    end

endmodule

`default_nettype wire

[rtl/slope_threshold_lick_detector.sv]
// ----------------------------------------------------------------------------
// slope_threshold_lick_detector
// Piezo lick detector: slope threshold with lick hold and minimum lick gap.
// ----------------------------------------------------------------------------
// Input stream: one transfer per ADC tick, i_s_tdata = {sample, now_ms}.
// Output stream: exactly one result transfer per input transfer, in order,
// o_m_tdata = {report_level, lick_now, event_code}.
// Pipeline: two register stages. The item is held in the input register,
// then the slope multiply/compare loads the result register, which drives
// o_m_tvalid and o_m_tdata. Throughput is one item per cycle while the
// receiver does not stall; the detector state is updated in the same cycle
// the result is registered, so the next item sees it.
// When the receiver stalls the result register holds and the input register
// still takes one more item; after that o_s_tready drops until the result
// is taken.
// Reset clears both pipeline stages, loads register defaults (threshold 397,
// lick hold 50 ms, min gap 200 ms, reporting off) and sets the lick flag.
// Configuration writes are taken in any cycle, meant while the stream is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module slope_threshold_lick_detector #(
    parameter  int SAMPLE_BITS = stl_pkg::SAMPLE_BITS_DEF,
    localparam int IN_W        = ((stl_pkg::TIME_W + SAMPLE_BITS + 7) / 8) * 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // tdata: now_ms[31:0], sample[SAMPLE_BITS-1:0], zero pad
    input  wire logic [IN_W-1:0]               i_s_tdata,
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    // tdata: event_code[1:0], lick_now, report_level, zero pad
    output logic [stl_pkg::OUT_W-1:0]          o_m_tdata,
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    input  wire logic                          i_cfg_we,
    input  wire logic [stl_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  wire logic [stl_pkg::CFG_W-1:0]     i_cfg_wdata
);

    localparam int RES_W = $bits(stl_pkg::t_result);

    stl_pkg::t_cfg              cfg;
    stl_pkg::t_result           result;
    logic                       r_in_valid;
    logic [stl_pkg::TIME_W-1:0] r_now_ms;
    logic [SAMPLE_BITS-1:0]     r_sample;
    logic                       r_out_valid;
    stl_pkg::t_result           r_result;
    logic                       advance;
    logic                       fire;

    assign advance    = !r_out_valid || i_m_tready;
    assign fire       = r_in_valid && advance;
    assign o_s_tready = !r_in_valid || advance;

    stl_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    stl_eval #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_eval (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_now_ms (r_now_ms),
        .i_sample (r_sample),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_now_ms <= i_s_tdata[stl_pkg::TIME_W-1:0];
            r_sample <= i_s_tdata[stl_pkg::TIME_W +: SAMPLE_BITS];
        end
        if (fire) begin
            r_result <= result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(stl_pkg::OUT_W - RES_W){1'b0}}, r_result};

endmodule

`default_nettype wire

[rtl/stl_checker.sv]
// ----------------------------------------------------------------------------
// stl_checker
// Port-level checks of the lick detector result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module stl_checker (
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic [stl_pkg::OUT_W-1:0] o_m_tdata,
    input wire logic                     o_m_tvalid,
    input wire logic                     i_m_tready
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    a_code_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[1:0] != 2'd3)
        else $error("illegal event code");

    a_lick_now_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[2] == (o_m_tdata[1:0] == stl_pkg::EV_START))
        else $error("lick_now disagrees with event code");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

endmodule

bind slope_threshold_lick_detector stl_checker u_stl_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tdata  (o_m_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready)
);

`default_nettype wire

[sim/tb_slope_threshold_lick_detector.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_slope_threshold_lick_detector
// Streams timestamped piezo samples into the lick detector and checks every
// result against an in-bench model of the hold, gap and slope rules, across
// several register settings with random stalls on both stream sides.
// ----------------------------------------------------------------------------

import stl_pkg::*;

class lick_scoreboard;
    localparam int SMP_W = SAMPLE_BITS_DEF;

    logic [CFG_W-1:0]  thr_q8;
    logic [CFG_W-1:0]  hold_ms;
    logic [CFG_W-1:0]  gap_ms;
    logic              rep_en;
    logic [TIME_W-1:0] last_eval;
    logic [TIME_W-1:0] last_lick;
    logic [SMP_W-1:0]  last_smp;
    logic              active;
    logic              rep_state;
    t_result           pending_events[$];
    int                errors;
    int                checked;
    int                ticks;
    int                starts;
    int                stops;

    function new();
        thr_q8    = SLOPE_THRESHOLD_RST;
        hold_ms   = LICK_HOLD_RST;
        gap_ms    = MIN_GAP_RST;
        rep_en    = 1'b0;
        last_eval = '0;
        last_lick = '0;
        last_smp  = '0;
        active    = 1'b1;
        rep_state = 1'b0;
        errors    = 0;
        checked   = 0;
        ticks     = 0;
        starts    = 0;
        stops     = 0;
    endfunction

    function void write_reg(t_cfg_idx idx, logic [CFG_W-1:0] val);
        case (idx)
            CFG_SLOPE_THRESHOLD: thr_q8  = val;
            CFG_LICK_HOLD:       hold_ms = val;
            CFG_MIN_GAP:         gap_ms  = val;
            CFG_REPORT_ENABLE:   rep_en  = val[0];
            default: ;
        endcase
    endfunction

    function void note_tick(logic [TIME_W-1:0] now, logic [SMP_W-1:0] smp);
        logic [TIME_W-1:0] dt;
        logic [TIME_W-1:0] since_lick;
        longint            rise_q8;
        longint            limit_q8;
        t_result           r;
        dt         = now - last_eval;
        since_lick = now - last_lick;
        r.event_code = EV_NONE;
        r.lick_now   = 1'b0;
        ticks++;
        if (dt > MIN_DT_MS && since_lick > TIME_W'(hold_ms)) begin
            rise_q8  = (longint'(smp) - longint'(last_smp)) * 256;
            limit_q8 = longint'(thr_q8) * longint'(dt);
            last_eval = now;
            last_smp  = smp;
            if (rise_q8 > limit_q8 && since_lick >= TIME_W'(gap_ms)) begin
                if (rep_en) rep_state = 1'b1;
                last_lick    = now;
                active       = 1'b1;
                r.event_code = EV_START;
                r.lick_now   = 1'b1;
                starts++;
            end else if (active) begin
                active = 1'b0;
                if (rep_en) rep_state = 1'b0;
                r.event_code = EV_STOP;
                stops++;
            end
        end
        r.report_level = rep_en & rep_state;
        pending_events.push_back(r);
    endfunction

    function void check_result(logic [OUT_W-1:0] tdata);
        t_result got;
        t_result want;
        got = t_result'(tdata[3:0]);
        checked++;
        if (pending_events.size() == 0) begin
            $error("result transfer with nothing expected: tdata=%02h", tdata);
            errors++;
            return;
        end
        want = pending_events.pop_front();
        if (got.event_code !== want.event_code) begin
            $error("event_code: expected %0d, got %0d", want.event_code, got.event_code);
            errors++;
        end
        if (got.lick_now !== want.lick_now) begin
            $error("lick_now: expected %0d, got %0d", want.lick_now, got.lick_now);
            errors++;
        end
        if (got.report_level !== want.report_level) begin
            $error("report_level: expected %0d, got %0d", want.report_level,
                   got.report_level);
            errors++;
        end
        if (tdata[OUT_W-1:4] !== '0) begin
            $error("pad: expected 0, got %0h", tdata[OUT_W-1:4]);
            errors++;
        end
    endfunction
endclass

module tb_slope_threshold_lick_detector;

    localparam int SMP_W = SAMPLE_BITS_DEF;
    localparam int IN_W  = ((TIME_W + SMP_W + 7) / 8) * 8;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic [IN_W-1:0]      i_s_tdata   = '0;
    logic                 i_s_tvalid  = 1'b0;
    logic                 o_s_tready;
    logic [OUT_W-1:0]     o_m_tdata;
    logic                 o_m_tvalid;
    logic                 i_m_tready  = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_addr  = '0;
    logic [CFG_W-1:0]     i_cfg_wdata = '0;

    lick_scoreboard sb = new();

    bit                steady = 1'b0;
    int                rx_hold = 0;
    int                settings_used = 1;
    logic [TIME_W-1:0] tick_ms;
    int                smp_level;

    slope_threshold_lick_detector dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tdata   (i_s_tdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // receiver: random backpressure, checks each result transfer
    always @(posedge i_clk) begin : rx
        int stall;
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata);
        if (rx_hold != 0) begin
            rx_hold    <= rx_hold - 1;
            i_m_tready <= 1'b0;
        end else begin
            stall = pick_gap();
            if (stall == 0) begin
                i_m_tready <= 1'b1;
            end else begin
                i_m_tready <= 1'b0;
                rx_hold    <= stall - 1;
            end
        end
    end

    task automatic send_tick(input logic [TIME_W-1:0] now, input logic [SMP_W-1:0] smp);
        int gap;
        gap = pick_gap();
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tdata  <= IN_W'({smp, now});
        i_s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_tick(now, smp);
    endtask

    task automatic drain_results();
        int waited;
        waited = 0;
        i_s_tvalid <= 1'b0;
        while (sb.pending_events.size() != 0 && waited < 2000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        sb.write_reg(idx, val);
    endtask

    task automatic apply_settings(input logic [CFG_W-1:0] thr, input logic [CFG_W-1:0] hold,
                                  input logic [CFG_W-1:0] gap, input logic rep);
        drain_results();
        write_reg(CFG_SLOPE_THRESHOLD, thr);
        write_reg(CFG_LICK_HOLD, hold);
        write_reg(CFG_MIN_GAP, gap);
        // upper bits of the enable word are don't-care
        write_reg(CFG_REPORT_ENABLE, {(CFG_W-1)'($urandom_range(0, 32767)), rep});
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    // baseline drift with occasional taps and random jumps in time
    task automatic run_random(input int n, input bit no_idle);
        int r;
        steady = no_idle;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 70)      tick_ms = tick_ms + $urandom_range(1, 10);
            else if (r < 90) tick_ms = tick_ms + $urandom_range(6, 80);
            else if (r < 97) tick_ms = tick_ms + $urandom_range(100, 600);
            else             tick_ms = $urandom;
            r = $urandom_range(0, 99);
            if (r < 60)      smp_level = smp_level + $urandom_range(0, 16) - 8;
            else if (r < 85) smp_level = smp_level + $urandom_range(30, 400);
            else if (r < 95) smp_level = $urandom_range(0, 100);
            else             smp_level = $urandom_range(0, (1 << SMP_W) - 1);
            if (smp_level < 0) smp_level = 0;
            if (smp_level > (1 << SMP_W) - 1) smp_level = (1 << SMP_W) - 1;
            send_tick(tick_ms, SMP_W'(smp_level));
            if ($urandom_range(0, 149) == 0) drain_results();
        end
        steady = 1'b0;
    endtask

    initial begin
        #20_000_000;
        $display("tb_slope_threshold_lick_detector NOT OK");
        $finish;
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: hold, min gap, wrap and exact-threshold cases
        send_tick(32'd0, 10'd5);
        send_tick(32'd3, 10'd0);
        send_tick(32'd40, 10'd1023);
        send_tick(32'd51, 10'd0);
        send_tick(32'd60, 10'd1023);
        send_tick(32'd66, 10'd0);
        send_tick(32'd250, 10'd1023);
        send_tick(32'd255, 10'd0);
        send_tick(32'd300, 10'd0);
        send_tick(32'd301, 10'd0);
        send_tick(32'hFFFF_FFF0, 10'd512);
        send_tick(32'h0000_0005, 10'd1023);
        send_tick(32'hFFFF_FFFF, 10'd1023);
        send_tick(32'd100, 10'd0);
        send_tick(32'd356, 10'd397);
        send_tick(32'd612, 10'd795);
        send_tick(32'd663, 10'd0);
        send_tick(32'd812, 10'd1023);
        send_tick(32'd1000, 10'h2AA);
        send_tick(32'd1010, 10'h155);

        tick_ms   = 32'd2000;
        smp_level = 0;
        run_random(280, 1'b0);
        apply_settings(16'd0, 16'd0, 16'd0, 1'b1);
        run_random(300, 1'b0);
        apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        run_random(300, 1'b0);
        apply_settings(SLOPE_THRESHOLD_RST, LICK_HOLD_RST, MIN_GAP_RST, 1'b1);
        run_random(300, 1'b1);
        apply_settings(CFG_W'($urandom_range(0, 2000)), CFG_W'($urandom_range(0, 100)),
                       CFG_W'($urandom_range(0, 400)), 1'b0);
        run_random(300, 1'b0);
        apply_settings(CFG_W'($urandom_range(0, 2000)), CFG_W'($urandom_range(0, 100)),
                       CFG_W'($urandom_range(0, 400)), 1'b1);
        run_random(300, 1'b0);

        drain_results();
        repeat (10) @(posedge i_clk);
        if (sb.pending_events.size() != 0) begin
            $error("%0d expected results never arrived", sb.pending_events.size());
            sb.errors++;
        end
        $display("Ran %0d samples over %0d register settings; %0d results compared.",
                 sb.ticks, settings_used, sb.checked);
        $display("Model saw %0d lick starts and %0d lick stops.", sb.starts, sb.stops);
        if (sb.errors == 0) begin
            $display("tb_slope_threshold_lick_detector OK");
        end else begin
            $display("tb_slope_threshold_lick_detector NOT OK");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/stl_pkg.sv
rtl/stl_cfg_regs.sv
rtl/stl_eval.sv
rtl/slope_threshold_lick_detector.sv
rtl/stl_checker.sv
sim/tb_slope_threshold_lick_detector.sv
